[src/gtp_pkg.sv]
// Shared widths, constants, register indexes and types of the go-to-point controller.
`timescale 1ns / 1ps

package gtp_pkg;

   // field widths
   localparam int POS_W      = 16;   // Q7.8 positions
   localparam int ANG_W      = 16;   // Q3.12 heading
   localparam int SD_W       = 15;   // stop distance
   localparam int RATE_W     = 14;   // turn rate clamp
   localparam int FWD_W      = 15;   // forward command
   localparam int TURN_W     = 15;   // turn command
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // internal widths
   localparam int DELTA_W = POS_W + 1;         // target minus robot
   localparam int SQ_W    = 2 * DELTA_W - 1;   // one squared delta
   localparam int D2_W    = SQ_W + 1;          // squared distance
   localparam int SDSQ_W  = 2 * SD_W;          // squared stop distance
   localparam int CXY_W   = 28;                // CORDIC x and y with gain headroom
   localparam int CZ_W    = 24;                // CORDIC angle, Q.20
   localparam int ERR_W   = 18;                // heading error before wrap

   localparam int PRESCALE_SHIFT = 8;
   localparam int BEARING_SHIFT  = 8;          // Q.20 down to Q3.12
   localparam int ATAN_LEN       = 20;
   localparam int CORDIC_ITER_DEF = 14;

   localparam logic signed [CZ_W-1:0]  HALF_PI_Q20 = 24'sd1647099;
   localparam logic signed [CZ_W-1:0]  ROUND_HALF  = 24'sd128;
   localparam logic signed [ERR_W-1:0] PI_Q12      = 18'sd12868;
   localparam logic signed [ERR_W-1:0] TWO_PI_Q12  = 18'sd25736;
   localparam logic signed [ERR_W-1:0] FOUR_PI_Q12 = 18'sd51472;

   // register reset values
   localparam logic signed [POS_W-1:0] TARGET_X_RST   = 16'sd256;
   localparam logic signed [POS_W-1:0] TARGET_Y_RST   = 16'sd256;
   localparam logic [SD_W-1:0]         STOP_DIST_RST  = 15'd51;
   localparam logic [SDSQ_W-1:0]       STOP_DSQ_RST   = 30'd2601;
   localparam logic [RATE_W-1:0]       TURN_RATE_RST  = 14'd410;
   localparam logic [FWD_W-1:0]        CRUISE_RST     = 15'd410;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TARGET_X      = 3'd0,
      CSR_TARGET_Y      = 3'd1,
      CSR_STOP_DISTANCE = 3'd2,
      CSR_MAX_TURN_RATE = 3'd3,
      CSR_CRUISE_SPEED  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic signed [POS_W-1:0] target_x;
      logic signed [POS_W-1:0] target_y;
      logic [SDSQ_W-1:0]       stop_dist_sq;
      logic [RATE_W-1:0]       max_turn_rate;
      logic [FWD_W-1:0]        cruise_speed;
   } csr_type;

   typedef struct packed {
      logic signed [CXY_W-1:0] x;
      logic signed [CXY_W-1:0] y;
      logic signed [CZ_W-1:0]  z;
      logic signed [ANG_W-1:0] head;
      logic                    arrived;
   } cordic_word_type;

   // rounded arctangent of 2^-idx in Q.20 radians
   function automatic logic signed [CZ_W-1:0] atan_q20(input int unsigned idx);
      case (idx)
         0:  return 24'sd823550;
         1:  return 24'sd486170;
         2:  return 24'sd256879;
         3:  return 24'sd130396;
         4:  return 24'sd65451;
         5:  return 24'sd32757;
         6:  return 24'sd16383;
         7:  return 24'sd8192;
         8:  return 24'sd4096;
         9:  return 24'sd2048;
         10: return 24'sd1024;
         11: return 24'sd512;
         12: return 24'sd256;
         13: return 24'sd128;
         14: return 24'sd64;
         15: return 24'sd32;
         16: return 24'sd16;
         17: return 24'sd8;
         18: return 24'sd4;
         19: return 24'sd2;
         default: return '0;
      endcase
   endfunction

endpackage

[src/gtp_req_if.sv]
// Pose channel: valid, ready and one pose word.
`timescale 1ns / 1ps

interface gtp_req_if import gtp_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [POS_W-1:0] robot_x;
   logic signed [POS_W-1:0] robot_y;
   logic signed [ANG_W-1:0] heading;

   modport source (output valid, output robot_x, output robot_y, output heading,
                   input ready);
   modport sink   (input valid, input robot_x, input robot_y, input heading,
                   output ready);
endinterface

[src/gtp_rsp_if.sv]
// Command channel: valid, ready and one command word.
`timescale 1ns / 1ps

interface gtp_rsp_if import gtp_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [FWD_W-1:0]         forward_cmd;
   logic signed [TURN_W-1:0] turn_cmd;
   logic                     arrived;

   modport source (output valid, output forward_cmd, output turn_cmd, output arrived,
                   input ready);
   modport sink   (input valid, input forward_cmd, input turn_cmd, input arrived,
                   output ready);
endinterface

[src/go_to_point_heading_controller.sv]
// Go-to-point heading controller top level: registers, front, CORDIC chain, back.
`timescale 1ns / 1ps
//
// Usage: each word on req_bus carries the robot pose (robot_x, robot_y in Q7.8
// metres, heading in Q3.12 radians). One command word comes back on rsp_bus for
// every pose: forward_cmd, turn_cmd (bearing to the target minus heading,
// wrapped to [-pi, pi] and clamped to max_turn_rate) and arrived, which zeroes
// both commands inside the stop radius.
// The target, stop radius, turn clamp and cruise speed are written through
// csr_we / csr_index / csr_wdata while no pose is in flight.
// Pipeline: three front stages, one stage per micro-rotation, three back
// stages. Throughput: one pose per cycle while rsp_bus.ready stays high;
// every stage holds one word and the chain of stage ready bits lets a word
// move whenever the next stage frees up.
// Reset clears every stage valid bit and loads the register defaults.
// When the receiver stalls the output word holds; words behind it close up
// into empty stages, so req_bus keeps accepting until the whole chain is full.
//
module go_to_point_heading_controller import gtp_pkg::*; #(
   parameter int unsigned CORDIC_ITERATIONS = CORDIC_ITER_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   gtp_req_if.sink               req_bus,
   gtp_rsp_if.source             rsp_bus,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   csr_type         csr;
   logic            chain_valid [0:CORDIC_ITERATIONS];
   logic            chain_ready [0:CORDIC_ITERATIONS];
   cordic_word_type chain_word  [0:CORDIC_ITERATIONS];

   gtp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .csr       (csr)
   );

   gtp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr),
      .req_bus   (req_bus),
      .out_valid (chain_valid[0]),
      .out_ready (chain_ready[0]),
      .out_word  (chain_word[0])
   );

   for (genvar i = 0; i < CORDIC_ITERATIONS; i++) begin : g_rot
      gtp_cordic_stage #(
         .SHIFT (i)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[i]),
         .in_ready  (chain_ready[i]),
         .in_word   (chain_word[i]),
         .out_valid (chain_valid[i+1]),
         .out_ready (chain_ready[i+1]),
         .out_word  (chain_word[i+1])
      );
   end

   gtp_back u_back (
      .clock    (clock),
      .reset    (reset),
      .csr      (csr),
      .in_valid (chain_valid[CORDIC_ITERATIONS]),
      .in_ready (chain_ready[CORDIC_ITERATIONS]),
      .in_word  (chain_word[CORDIC_ITERATIONS]),
      .rsp_bus  (rsp_bus)
   );

endmodule

[src/gtp_csr.sv]
// Configuration registers and the squared stop distance.
`timescale 1ns / 1ps

module gtp_csr import gtp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output csr_type               csr
);

   logic signed [POS_W-1:0] target_x_ff, target_x_in;
   logic signed [POS_W-1:0] target_y_ff, target_y_in;
   logic [SD_W-1:0]         stop_dist_ff, stop_dist_in;
   logic [SDSQ_W-1:0]       stop_dsq_ff, stop_dsq_in;
   logic [RATE_W-1:0]       turn_rate_ff, turn_rate_in;
   logic [FWD_W-1:0]        cruise_ff, cruise_in;

   always_comb begin
      target_x_in  = target_x_ff;
      target_y_in  = target_y_ff;
      stop_dist_in = stop_dist_ff;
      turn_rate_in = turn_rate_ff;
      cruise_in    = cruise_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_TARGET_X:      target_x_in  = signed'(csr_wdata[POS_W-1:0]);
            CSR_TARGET_Y:      target_y_in  = signed'(csr_wdata[POS_W-1:0]);
            CSR_STOP_DISTANCE: stop_dist_in = csr_wdata[SD_W-1:0];
            CSR_MAX_TURN_RATE: turn_rate_in = csr_wdata[RATE_W-1:0];
            CSR_CRUISE_SPEED:  cruise_in    = csr_wdata[FWD_W-1:0];
            default: ;
         endcase
      end
   end

   // square is registered from the stop distance register, in the cycle after a write
   assign stop_dsq_in = SDSQ_W'(stop_dist_ff) * SDSQ_W'(stop_dist_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         target_x_ff  <= TARGET_X_RST;
         target_y_ff  <= TARGET_Y_RST;
         stop_dist_ff <= STOP_DIST_RST;
         stop_dsq_ff  <= STOP_DSQ_RST;
         turn_rate_ff <= TURN_RATE_RST;
         cruise_ff    <= CRUISE_RST;
      end else begin
         target_x_ff  <= target_x_in;
         target_y_ff  <= target_y_in;
         stop_dist_ff <= stop_dist_in;
         stop_dsq_ff  <= stop_dsq_in;
         turn_rate_ff <= turn_rate_in;
         cruise_ff    <= cruise_in;
      end
   end

   assign csr.target_x      = target_x_ff;
   assign csr.target_y      = target_y_ff;
   assign csr.stop_dist_sq  = stop_dsq_ff;
   assign csr.max_turn_rate = turn_rate_ff;
   assign csr.cruise_speed  = cruise_ff;

endmodule

[src/gtp_front.sv]
// Front stages: target delta, squared distance compare and CORDIC pre-rotation.
`timescale 1ns / 1ps

module gtp_front import gtp_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  csr_type         csr,
   gtp_req_if.sink         req_bus,
   output logic            out_valid,
   input  logic            out_ready,
   output cordic_word_type out_word
);

   logic v1_ff, v2_ff, v3_ff;
   logic rdy1, rdy2, rdy3;

   // stage 1: deltas
   logic signed [DELTA_W-1:0] dx1_ff, dx1_in, dy1_ff, dy1_in;
   logic signed [ANG_W-1:0]   head1_ff;

   // stage 2: squares and pre-rotation
   logic [SQ_W-1:0]           dx2_ff, dx2_in, dy2_ff, dy2_in;
   logic signed [2*DELTA_W-1:0] dx_prod, dy_prod;
   logic signed [CXY_W-1:0]   x2_ff, x2_in, y2_ff, y2_in;
   logic signed [CXY_W-1:0]   xs, ys;
   logic signed [CZ_W-1:0]    z2_ff, z2_in;
   logic signed [ANG_W-1:0]   head2_ff;

   // stage 3: arrival compare
   logic [D2_W-1:0]           d2;
   cordic_word_type           word3_ff, word3_in;

   assign rdy3 = !v3_ff || out_ready;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign req_bus.ready = rdy1;

   assign dx1_in = DELTA_W'(csr.target_x) - DELTA_W'(req_bus.robot_x);
   assign dy1_in = DELTA_W'(csr.target_y) - DELTA_W'(req_bus.robot_y);

   assign dx_prod = (2*DELTA_W)'(dx1_ff) * (2*DELTA_W)'(dx1_ff);
   assign dy_prod = (2*DELTA_W)'(dy1_ff) * (2*DELTA_W)'(dy1_ff);
   assign dx2_in  = dx_prod[SQ_W-1:0];
   assign dy2_in  = dy_prod[SQ_W-1:0];

   assign xs = CXY_W'(dx1_ff) <<< PRESCALE_SHIFT;
   assign ys = CXY_W'(dy1_ff) <<< PRESCALE_SHIFT;

   // rotate the left half plane into the right by a quarter turn
   always_comb begin
      x2_in = xs;
      y2_in = ys;
      z2_in = '0;
      if (xs < 0) begin
         if (ys >= 0) begin
            x2_in = ys;
            y2_in = -xs;
            z2_in = HALF_PI_Q20;
         end else begin
            x2_in = -ys;
            y2_in = xs;
            z2_in = -HALF_PI_Q20;
         end
      end
   end

   assign d2 = D2_W'(dx2_ff) + D2_W'(dy2_ff);

   always_comb begin
      word3_in.x       = x2_ff;
      word3_in.y       = y2_ff;
      word3_in.z       = z2_ff;
      word3_in.head    = head2_ff;
      word3_in.arrived = d2 <= D2_W'(csr.stop_dist_sq);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_bus.valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1 && req_bus.valid) begin
         dx1_ff   <= dx1_in;
         dy1_ff   <= dy1_in;
         head1_ff <= req_bus.heading;
      end
      if (rdy2 && v1_ff) begin
         dx2_ff   <= dx2_in;
         dy2_ff   <= dy2_in;
         x2_ff    <= x2_in;
         y2_ff    <= y2_in;
         z2_ff    <= z2_in;
         head2_ff <= head1_ff;
      end
      if (rdy3 && v2_ff) begin
         word3_ff <= word3_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_word  = word3_ff;

endmodule

[src/gtp_cordic_stage.sv]
// One vectoring CORDIC micro-rotation as a register stage.
`timescale 1ns / 1ps

module gtp_cordic_stage import gtp_pkg::*; #(
   parameter int unsigned SHIFT = 0
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  cordic_word_type in_word,
   output logic            out_valid,
   input  logic            out_ready,
   output cordic_word_type out_word
);

   localparam logic signed [CZ_W-1:0] ANGLE = atan_q20(SHIFT);

   logic                    valid_ff;
   cordic_word_type         word_ff, word_in;
   logic signed [CXY_W-1:0] xs, ys;

   assign in_ready = !valid_ff || out_ready;

   assign xs = in_word.x >>> SHIFT;
   assign ys = in_word.y >>> SHIFT;

   // drive y toward zero, accumulate the angle turned
   always_comb begin
      word_in = in_word;
      if (in_word.y >= 0) begin
         word_in.x = in_word.x + ys;
         word_in.y = in_word.y - xs;
         word_in.z = in_word.z + ANGLE;
      end else begin
         word_in.x = in_word.x - ys;
         word_in.y = in_word.y + xs;
         word_in.z = in_word.z - ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

[src/gtp_back.sv]
// Back stages: bearing rounding, heading error wrap, clamp and command register.
`timescale 1ns / 1ps

module gtp_back import gtp_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  csr_type         csr,
   input  logic            in_valid,
   output logic            in_ready,
   input  cordic_word_type in_word,
   gtp_rsp_if.source       rsp_bus
);

   logic v1_ff, v2_ff, v3_ff;
   logic rdy1, rdy2, rdy3;

   // stage 1: bearing minus heading
   logic signed [CZ_W-1:0]  z_round, z_shift;
   logic signed [ERR_W-1:0] err1_ff, err1_in;
   logic                    arr1_ff;

   // stage 2: wrap into [-pi, pi]
   logic signed [ERR_W-1:0] err2_ff, err2_in;
   logic signed [ERR_W-1:0] sub1, sub2, add1, add2;
   logic                    arr2_ff;

   // stage 3: clamp and output
   logic signed [ERR_W-1:0] lim, clamped;
   logic [FWD_W-1:0]         fwd_ff, fwd_in;
   logic signed [TURN_W-1:0] turn_ff, turn_in;
   logic                     arr3_ff;

   assign rdy3 = !v3_ff || rsp_bus.ready;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign in_ready = rdy1;

   assign z_round = in_word.z + ROUND_HALF;
   assign z_shift = z_round >>> BEARING_SHIFT;
   assign err1_in = ERR_W'(z_shift) - ERR_W'(in_word.head);

   assign sub1 = err1_ff - TWO_PI_Q12;
   assign sub2 = err1_ff - FOUR_PI_Q12;
   assign add1 = err1_ff + TWO_PI_Q12;
   assign add2 = err1_ff + FOUR_PI_Q12;

   // at most two whole turns off for any heading word
   always_comb begin
      err2_in = err1_ff;
      if (err1_ff > PI_Q12) begin
         err2_in = (sub1 > PI_Q12) ? sub2 : sub1;
      end else if (err1_ff < -PI_Q12) begin
         err2_in = (add1 < -PI_Q12) ? add2 : add1;
      end
   end

   assign lim = signed'(ERR_W'(csr.max_turn_rate));

   always_comb begin
      clamped = err2_ff;
      if (err2_ff > lim) begin
         clamped = lim;
      end else if (err2_ff < -lim) begin
         clamped = -lim;
      end
   end

   assign turn_in = arr2_ff ? '0 : clamped[TURN_W-1:0];
   assign fwd_in  = arr2_ff ? '0 : csr.cruise_speed;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= in_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1 && in_valid) begin
         err1_ff <= err1_in;
         arr1_ff <= in_word.arrived;
      end
      if (rdy2 && v1_ff) begin
         err2_ff <= err2_in;
         arr2_ff <= arr1_ff;
      end
      if (rdy3 && v2_ff) begin
         fwd_ff  <= fwd_in;
         turn_ff <= turn_in;
         arr3_ff <= arr2_ff;
      end
   end

   assign rsp_bus.valid       = v3_ff;
   assign rsp_bus.forward_cmd = fwd_ff;
   assign rsp_bus.turn_cmd    = turn_ff;
   assign rsp_bus.arrived     = arr3_ff;

endmodule

[src/gtp_checker.sv]
// Port-level checks on the command channel, bound to the top level.
`timescale 1ns / 1ps

module gtp_checker import gtp_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [FWD_W-1:0]         rsp_forward_cmd,
   input logic signed [TURN_W-1:0] rsp_turn_cmd,
   input logic                     rsp_arrived
);

   localparam logic signed [TURN_W-1:0] PI_TURN = TURN_W'(PI_Q12);

   // nothing comes out of a freshly reset pipeline
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("command word valid right after reset");

   a_arrived_stops: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_arrived |-> rsp_forward_cmd == '0 && rsp_turn_cmd == '0)
      else $error("arrived word carries a nonzero command");

   a_turn_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_turn_cmd <= PI_TURN && rsp_turn_cmd >= -PI_TURN)
      else $error("turn command outside [-pi, pi]");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_forward_cmd) &&
         $stable(rsp_turn_cmd) && $stable(rsp_arrived))
      else $error("stalled command word changed");

endmodule

bind go_to_point_heading_controller gtp_checker u_gtp_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_forward_cmd (rsp_bus.forward_cmd),
   .rsp_turn_cmd    (rsp_bus.turn_cmd),
   .rsp_arrived     (rsp_bus.arrived)
);

[verif/go_to_point_heading_controller_tb.sv]
// Self-checking testbench for the go-to-point heading controller.
`timescale 1ns / 1ps

module go_to_point_heading_controller_tb;
   import gtp_pkg::*;

   localparam int CORDIC_STEPS   = 14;
   localparam int LATENCY        = CORDIC_STEPS + 6;
   localparam int IDLE_LIMIT     = 2000;
   localparam int PHASES         = 6;
   localparam int POSES_PER_PHASE = 225;

   localparam longint QUARTER_TURN_Q20 = 1647099;
   localparam longint HALF_TURN_Q12    = 12868;
   localparam longint FULL_TURN_Q12    = 25736;

   typedef struct packed {
      logic signed [POS_W-1:0] robot_x;
      logic signed [POS_W-1:0] robot_y;
      logic signed [ANG_W-1:0] heading;
   } pose_word_type;

   typedef struct packed {
      logic [FWD_W-1:0]         forward_cmd;
      logic signed [TURN_W-1:0] turn_cmd;
      logic                     arrived;
   } cmd_word_type;

   typedef struct packed {
      logic signed [POS_W-1:0] target_x;
      logic signed [POS_W-1:0] target_y;
      logic [SD_W-1:0]         stop_dist;
      logic [RATE_W-1:0]       turn_limit;
      logic [FWD_W-1:0]        cruise;
   } setup_word_type;

   typedef struct {
      bit            is_write;
      csr_index_type reg_idx;
      logic [CSR_DATA_W-1:0] reg_val;
      pose_word_type pose;
      bit            typed;
      cmd_word_type  cmd;
   } plan_row_type;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_kind_type;

   logic clock;
   logic reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   gtp_req_if req_bus ();
   gtp_rsp_if rsp_bus ();

   go_to_point_heading_controller #(.CORDIC_ITERATIONS(CORDIC_STEPS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // register mirror, starts at the reset values
   logic signed [POS_W-1:0] cfg_target_x = 16'sd256;
   logic signed [POS_W-1:0] cfg_target_y = 16'sd256;
   logic [SD_W-1:0]         cfg_stop = 15'd51;
   logic [RATE_W-1:0]       cfg_turn_limit = 14'd410;
   logic [FWD_W-1:0]        cfg_cruise = 15'd410;

   longint atan_step_q20 [0:19] = '{
      823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
      4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2
   };

   cmd_word_type   pending_cmds [$];
   plan_row_type   plan [$];
   bit             drive_typed;
   cmd_word_type   drive_cmd;
   cmd_word_type   expected_cmd;
   pose_word_type  seen_pose;
   int             mismatch_count = 0;
   int             result_count = 0;
   int             idle_cycles = 0;
   int             burst_left;
   longint         cycle_count = 0;
   stall_kind_type stall_mode = STALL_NONE;
   int             stall_left = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      $display("%0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // bearing of (dx, dy) in Q.20 radians by vectoring micro-rotations
   function automatic longint bearing_q20(input longint dx, input longint dy);
      longint x, y, z, t, xs, ys;
      x = dx * 256;
      y = dy * 256;
      z = 0;
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y;
            y = -t;
            z = QUARTER_TURN_Q20;
         end else begin
            x = -y;
            y = t;
            z = -QUARTER_TURN_Q20;
         end
      end
      for (int i = 0; i < CORDIC_STEPS && i < 20; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            z = z + atan_step_q20[i];
         end else begin
            x = x - ys;
            y = y + xs;
            z = z - atan_step_q20[i];
         end
      end
      return z;
   endfunction

   function automatic cmd_word_type command_for_pose(input pose_word_type p);
      longint tx, ty, rx, ry, dx, dy, dist_sq, stop_sq, err, lim;
      cmd_word_type c;
      tx = longint'(cfg_target_x);
      ty = longint'(cfg_target_y);
      rx = longint'(p.robot_x);
      ry = longint'(p.robot_y);
      dx = tx - rx;
      dy = ty - ry;
      dist_sq = dx * dx + dy * dy;
      stop_sq = longint'(cfg_stop) * longint'(cfg_stop);
      c = '0;
      if (dist_sq <= stop_sq) begin
         c.arrived = 1'b1;
      end else begin
         lim = longint'(cfg_turn_limit);
         err = ((bearing_q20(dx, dy) + 128) >>> 8) - longint'(p.heading);
         while (err > HALF_TURN_Q12) err = err - FULL_TURN_Q12;
         while (err < -HALF_TURN_Q12) err = err + FULL_TURN_Q12;
         if (err > lim) err = lim;
         if (err < -lim) err = -lim;
         c.turn_cmd = err[TURN_W-1:0];
         c.forward_cmd = cfg_cruise;
      end
      return c;
   endfunction

   // expectations and checks on every accepted word
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            seen_pose.robot_x = req_bus.robot_x;
            seen_pose.robot_y = req_bus.robot_y;
            seen_pose.heading = req_bus.heading;
            pending_cmds.push_back(drive_typed ? drive_cmd : command_for_pose(seen_pose));
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            result_count++;
            if (pending_cmds.size() == 0) begin
               report_mismatch($sformatf("result %0d arrived with nothing pending",
                                         result_count));
            end else begin
               expected_cmd = pending_cmds.pop_front();
               if (rsp_bus.forward_cmd !== expected_cmd.forward_cmd)
                  report_mismatch($sformatf("result %0d forward_cmd: got %0d, expected %0d",
                     result_count, rsp_bus.forward_cmd, expected_cmd.forward_cmd));
               if (rsp_bus.turn_cmd !== expected_cmd.turn_cmd)
                  report_mismatch($sformatf("result %0d turn_cmd: got %0d, expected %0d",
                     result_count, $signed(rsp_bus.turn_cmd), $signed(expected_cmd.turn_cmd)));
               if (rsp_bus.arrived !== expected_cmd.arrived)
                  report_mismatch($sformatf("result %0d arrived: got %0b, expected %0b",
                     result_count, rsp_bus.arrived, expected_cmd.arrived));
            end
         end
      end
   end

   // receiver: stall modes of random length
   always @(posedge clock) begin
      cycle_count++;
      if (stall_left == 0) begin
         stall_mode = stall_kind_type'($urandom_range(0, 3));
         stall_left = $urandom_range(8, 200);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         STALL_NONE:  rsp_bus.ready <= 1'b1;
         STALL_LIGHT: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
         STALL_HEAVY: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
         default:     rsp_bus.ready <= (cycle_count % 3 == 0);
      endcase
   end

   // watchdog on cycles without any accepted word
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // step off the edge first so a word accepted at this edge is already pending
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (pending_cmds.size() != 0) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic send_pose(input pose_word_type p, input bit typed, input cmd_word_type c);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         if ($urandom_range(0, 29) == 0) begin
            // hold off until the pipeline is empty
            wait_drained();
         end else begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
               req_bus.valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
      burst_left--;
      req_bus.valid   <= 1'b1;
      req_bus.robot_x <= p.robot_x;
      req_bus.robot_y <= p.robot_y;
      req_bus.heading <= p.heading;
      drive_typed     <= typed;
      drive_cmd       <= c;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // caller lowers csr_we after the last write of a batch
   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_TARGET_X:      cfg_target_x = val;
         CSR_TARGET_Y:      cfg_target_y = val;
         CSR_STOP_DISTANCE: cfg_stop = val[SD_W-1:0];
         CSR_MAX_TURN_RATE: cfg_turn_limit = val[RATE_W-1:0];
         CSR_CRUISE_SPEED:  cfg_cruise = val[FWD_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic apply_setup(input setup_word_type s);
      write_csr(CSR_TARGET_X, s.target_x);
      write_csr(CSR_TARGET_Y, s.target_y);
      write_csr(CSR_STOP_DISTANCE, {1'b0, s.stop_dist});
      write_csr(CSR_MAX_TURN_RATE, {2'b0, s.turn_limit});
      write_csr(CSR_CRUISE_SPEED, {1'b0, s.cruise});
      csr_we <= 1'b0;
   endtask

   function automatic void add_pose(input int x, input int y, input int h);
      plan_row_type r;
      r.is_write = 0;
      r.reg_idx = CSR_TARGET_X;
      r.reg_val = '0;
      r.pose = '{x[POS_W-1:0], y[POS_W-1:0], h[ANG_W-1:0]};
      r.typed = 0;
      r.cmd = '0;
      plan.push_back(r);
   endfunction

   function automatic void add_checked(input int x, input int y, input int h,
                                       input int fwd, input int turn, input bit arr);
      add_pose(x, y, h);
      plan[$].typed = 1;
      plan[$].cmd = '{fwd[FWD_W-1:0], turn[TURN_W-1:0], arr};
   endfunction

   function automatic void add_write(input csr_index_type idx, input int val);
      plan_row_type r;
      r.is_write = 1;
      r.reg_idx = idx;
      r.reg_val = val[CSR_DATA_W-1:0];
      r.pose = '0;
      r.typed = 0;
      r.cmd = '0;
      plan.push_back(r);
   endfunction

   function automatic setup_word_type pick_setup(input int phase);
      setup_word_type s;
      s.target_x = POS_W'(($urandom_range(0, 3) == 0) ? $urandom
                                                      : int'($urandom_range(0, 4096)) - 2048);
      s.target_y = POS_W'(($urandom_range(0, 3) == 0) ? $urandom
                                                      : int'($urandom_range(0, 4096)) - 2048);
      s.stop_dist = SD_W'(($urandom_range(0, 2) == 0) ? $urandom_range(0, 32767)
                                                      : $urandom_range(0, 1500));
      s.turn_limit = RATE_W'($urandom_range(0, 12868));
      s.cruise = FWD_W'($urandom_range(0, 32767));
      case (phase)
         1: begin
            s.target_x = -16'sd32768;
            s.target_y = -16'sd32768;
            s.stop_dist = 15'd0;
            s.turn_limit = 14'd12868;
            s.cruise = 15'd32767;
         end
         2: begin
            s.target_x = 16'sd32767;
            s.target_y = 16'sd32767;
            s.stop_dist = 15'd32767;
            s.turn_limit = 14'd0;
            s.cruise = 15'd0;
         end
         default: ;
      endcase
      return s;
   endfunction

   // mostly poses around the target so both sides of the stop radius get hit
   function automatic pose_word_type random_pose();
      pose_word_type p;
      int span, pick;
      pick = $urandom_range(0, 9);
      span = (pick < 2) ? 4 : int'(cfg_stop) * 2 + 16;
      if (pick < 6) begin
         p.robot_x = POS_W'(int'(cfg_target_x) + (int'($urandom_range(0, 2 * span)) - span));
         p.robot_y = POS_W'(int'(cfg_target_y) + (int'($urandom_range(0, 2 * span)) - span));
      end else begin
         p.robot_x = POS_W'($urandom);
         p.robot_y = POS_W'($urandom);
      end
      p.heading = ANG_W'(($urandom_range(0, 1) == 0) ? $urandom
                                                     : int'($urandom_range(0, 25736)) - 12868);
      return p;
   endfunction

   initial begin
      bit in_writes;
      reset              <= 1'b1;
      csr_we             <= 1'b0;
      csr_index          <= '0;
      csr_wdata          <= '0;
      req_bus.valid      <= 1'b0;
      req_bus.robot_x    <= '0;
      req_bus.robot_y    <= '0;
      req_bus.heading    <= '0;
      drive_typed        <= 1'b0;
      drive_cmd          <= '0;
      burst_left = 0;
      in_writes = 0;

      // reset settings: target (256, 256), stop 51, turn limit 410, cruise 410
      add_checked(256, 256, 0, 0, 0, 1);           // robot on target
      add_checked(256, 256, -32768, 0, 0, 1);      // on target, extreme heading
      add_checked(205, 256, 0, 0, 0, 1);           // exactly on the stop radius
      add_pose(204, 256, 0);                       // just outside it
      add_checked(0, 0, 0, 410, 410, 0);           // clamp on the positive side
      add_checked(512, 512, 0, 410, -410, 0);      // clamp on the negative side
      add_pose(-32768, -32768, 32767);             // heading beyond pi wraps
      add_pose(32767, 32767, -32768);
      add_pose(32767, -32768, 0);
      add_pose(-32768, 32767, 16384);
      add_pose(256, 0, 6434);
      add_pose(0, 256, 12868);
      add_pose(512, 256, 0);                       // target straight behind
      // turn limit at pi, zero stop radius, top cruise, target in a corner
      add_write(CSR_MAX_TURN_RATE, 12868);
      add_write(CSR_STOP_DISTANCE, 0);
      add_write(CSR_CRUISE_SPEED, 32767);
      add_write(CSR_TARGET_X, -32768);
      add_write(CSR_TARGET_Y, 32767);
      add_checked(-32768, 32767, 0, 0, 0, 1);      // on target with zero radius
      add_pose(-32767, 32767, 0);
      add_pose(-32768, 32766, -32768);
      add_pose(32767, -32768, 1000);
      add_pose(0, 0, 32767);
      // widest radius, no turning, no cruise
      add_write(CSR_STOP_DISTANCE, 32767);
      add_write(CSR_MAX_TURN_RATE, 0);
      add_write(CSR_CRUISE_SPEED, 0);
      add_write(CSR_TARGET_X, 32767);
      add_write(CSR_TARGET_Y, -32768);
      add_checked(0, 0, 0, 0, 0, 0);
      add_checked(12767, -32768, 5, 0, 0, 1);
      add_pose(-32768, 32767, 0);                  // largest distance

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[r]) begin
         if (plan[r].is_write) begin
            if (!in_writes) begin
               wait_drained();
               in_writes = 1;
            end
            write_csr(plan[r].reg_idx, plan[r].reg_val);
         end else begin
            if (in_writes) begin
               csr_we <= 1'b0;
               in_writes = 0;
            end
            send_pose(plan[r].pose, plan[r].typed, plan[r].cmd);
         end
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         wait_drained();
         apply_setup(pick_setup(ph));
         for (int n = 0; n < POSES_PER_PHASE; n++)
            send_pose(random_pose(), 1'b0, '0);
      end

      wait_drained();
      repeat (LATENCY + 10) @(posedge clock);
      if (pending_cmds.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", pending_cmds.size()));

      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
